>>> rtl/spr_pkg.sv
// shared types and constants for the serial phrase rom reader
// no dependencies; imported by spr_rom and serial_phrase_rom_reader_top
package spr_pkg;

    localparam int ROM_INDEX_BITS = 14;
    localparam int ROM_DEPTH      = 1 << ROM_INDEX_BITS;
    localparam int ADDR_BITS      = 20;
    localparam int NIBBLE_BITS    = 4;
    localparam int BYTE_BITS      = 8;
    localparam int BIT_POS_BITS   = $clog2(BYTE_BITS);

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    typedef struct packed {
        logic [1:0]                op;
        logic [NIBBLE_BITS-1:0]    nibble;
        logic [ROM_INDEX_BITS-1:0] rom_index;
        logic [BYTE_BITS-1:0]      rom_byte;
    } spr_in_t;

    typedef struct packed {
        logic                 data_bit;
        logic                 data_drive;
        logic [ADDR_BITS-1:0] address_now;
    } spr_out_t;

    typedef struct packed {
        logic                      en;
        logic [ROM_INDEX_BITS-1:0] addr;
        logic [BYTE_BITS-1:0]      data;
    } spr_rom_wr_t;

    typedef struct packed {
        logic                      en;
        logic [ROM_INDEX_BITS-1:0] addr;
    } spr_rom_rd_t;

endpackage

>>> rtl/spr_rom.sv
// phrase byte store: one write port, one read port with registered data
// depends on spr_pkg
module spr_rom
    import spr_pkg::*;
(
    input  logic                 clk,
    input  spr_rom_wr_t          wr,
    input  spr_rom_rd_t          rd,
    output logic [BYTE_BITS-1:0] rd_data
);

    logic [BYTE_BITS-1:0] mem [ROM_DEPTH];
    logic [BYTE_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read data holds until the next fetch; it stands in for the shift byte
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/serial_phrase_rom_reader_top.sv
// serial phrase rom reader top level: event decode, address and bit state, result register
// depends on spr_pkg and spr_rom
//
// Takes one event per clock (read strobe, load-address strobe or rom byte write) and returns
// one result per event through a single output register; an event is taken whenever that
// register is empty or being emptied in the same cycle. Each result is registered at the input
// transfer. A byte fetch uses the single read port of the 16K x 8 byte store, whose
// registered read data serves as the shift byte for the following read strobes. The store
// needs no clearing after reset; entries must be written before they are read.
module serial_phrase_rom_reader_top
    import spr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  spr_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output spr_out_t out_data
);

    logic                    in_xfer;
    logic [ADDR_BITS-1:0]    address_reg, address_next;
    logic                    ready_seen_reg, ready_seen_next;
    logic [BIT_POS_BITS-1:0] bit_pos_reg, bit_pos_next;
    logic                    pin_level_reg, pin_level_next;
    logic                    pin_driven_reg, pin_driven_next;
    logic                    out_valid_reg;
    spr_out_t                out_data_reg, out_data_next;
    spr_rom_wr_t             rom_wr;
    spr_rom_rd_t             rom_rd;
    logic [BYTE_BITS-1:0]    shift_byte;

    assign in_stall = out_valid_reg && out_stall;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        address_next    = address_reg;
        ready_seen_next = ready_seen_reg;
        bit_pos_next    = bit_pos_reg;
        pin_level_next  = pin_level_reg;
        pin_driven_next = pin_driven_reg;
        rom_wr.en       = 1'b0;
        rom_wr.addr     = in_data.rom_index;
        rom_wr.data     = in_data.rom_byte;
        rom_rd.en       = 1'b0;
        if (in_xfer)
        begin
            case (in_data.op)
                OP_READ:
                begin
                    if (!ready_seen_reg)
                    begin
                        ready_seen_next = 1'b1;
                        bit_pos_next    = '0;
                        pin_driven_next = 1'b1;
                        pin_level_next  = 1'b1;
                        rom_rd.en       = 1'b1;
                    end
                    else
                    begin
                        pin_level_next = shift_byte[bit_pos_reg];
                        bit_pos_next   = bit_pos_reg + 1'b1;
                        // last bit of the byte: step the address and fetch the next byte
                        if (bit_pos_reg == BIT_POS_BITS'(BYTE_BITS - 1))
                        begin
                            address_next = address_reg + 1'b1;
                            rom_rd.en    = 1'b1;
                        end
                    end
                end
                OP_LOAD:
                begin
                    pin_driven_next = 1'b0;
                    ready_seen_next = 1'b0;
                    address_next    = {in_data.nibble, address_reg[ADDR_BITS-1:NIBBLE_BITS]};
                end
                OP_WRITE:
                begin
                    rom_wr.en = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        rom_rd.addr = address_next[ROM_INDEX_BITS-1:0];

        out_data_next.data_bit    = pin_driven_next && pin_level_next;
        out_data_next.data_drive  = pin_driven_next;
        out_data_next.address_now = address_next;
    end

    spr_rom u_rom (
        .clk     (clk),
        .wr      (rom_wr),
        .rd      (rom_rd),
        .rd_data (shift_byte)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_reg    <= '0;
            ready_seen_reg <= 1'b0;
            bit_pos_reg    <= '0;
            pin_level_reg  <= 1'b0;
            pin_driven_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            address_reg    <= address_next;
            ready_seen_reg <= ready_seen_next;
            bit_pos_reg    <= bit_pos_next;
            pin_level_reg  <= pin_level_next;
            pin_driven_reg <= pin_driven_next;
            if (in_xfer)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a load always releases the pin in its own result
    a_load_releases: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && in_data.op == OP_LOAD |=> out_valid && !out_data.data_drive)
        else $error("load transfer did not release the data pin");

    // a read strobe always leaves the pin driven
    a_read_drives: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && in_data.op == OP_READ |=> out_valid && out_data.data_drive && ready_seen_reg)
        else $error("read transfer left the data pin released");

    // bit pointer moves only on a read transfer
    a_bit_pos_steady: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_xfer && in_data.op == OP_READ) |=> bit_pos_reg == $past(bit_pos_reg))
        else $error("bit pointer changed without a read transfer");

    // address holds without a transfer (it moves only on a load or a read's byte boundary)
    a_addr_steady: assert property (@(posedge clk) disable iff (!rst_n)
        !in_xfer |=> address_reg == $past(address_reg))
        else $error("address changed without a transfer");

endmodule

>>> verif/tb_serial_phrase_rom_reader_top.sv
// testbench for serial_phrase_rom_reader_top: directed and random strobe and rom write events
// depends on spr_pkg and serial_phrase_rom_reader_top; self-checking against a local predictor
module tb_serial_phrase_rom_reader_top
    import spr_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_SPARE    = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         RANDOM_ITEMS = 1700;
    localparam int         IDLE_PCT    = 14;
    localparam int         REPORT_MAX  = 10;

    typedef struct {
        spr_in_t ev;
        logic    hold;
    } stim_item_t;

    // addressing only, used to keep every fetched rom entry written
    typedef struct packed {
        logic [ADDR_BITS-1:0]    addr;
        logic                    ready;
        logic [BIT_POS_BITS:0]   bit_pos;
    } fetch_plan_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    spr_in_t  in_data = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    spr_out_t out_data;

    serial_phrase_rom_reader_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // predictor state
    logic [ADDR_BITS-1:0]    rd_addr = '0;
    logic                    rd_ready = 1'b0;
    logic [BYTE_BITS-1:0]    rd_shift = 8'hFF;
    logic [BIT_POS_BITS:0]   rd_bit_pos = '0;
    logic                    rd_pin_level = 1'b0;
    logic                    rd_pin_driven = 1'b0;
    logic [BYTE_BITS-1:0]    rom_image [0:ROM_DEPTH-1];

    // stimulus side bookkeeping
    fetch_plan_t             plan = '0;
    bit                      rom_written [0:ROM_DEPTH-1];
    logic                    hold_pending = 1'b0;
    int                      queued_count = 0;

    stim_item_t              pending_events [$];
    spr_out_t                expected_outputs [$];
    int                      accepted_count = 0;
    int                      error_count = 0;
    int                      cycle_count = 0;
    logic                    calm;

    assign calm = (accepted_count >= 700) && (accepted_count < 1000);

    initial begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("serial_phrase_rom_reader_top verification failed");
            $finish;
        end
    end

    task automatic predict_reader_output(input spr_in_t ev, output spr_out_t res);
        case (ev.op)
            OP_READ: begin
                if (!rd_ready) begin
                    rd_ready      = 1'b1;
                    rd_shift      = rom_image[rd_addr[ROM_INDEX_BITS-1:0]];
                    rd_bit_pos    = '0;
                    rd_pin_driven = 1'b1;
                    rd_pin_level  = 1'b1;
                end else begin
                    rd_pin_level = rd_shift[rd_bit_pos[BIT_POS_BITS-1:0]];
                    rd_bit_pos   = rd_bit_pos + 1'b1;
                end
                // byte done: step the address and fetch the next one
                if (rd_bit_pos == BYTE_BITS) begin
                    rd_addr    = rd_addr + 1'b1;
                    rd_shift   = rom_image[rd_addr[ROM_INDEX_BITS-1:0]];
                    rd_bit_pos = '0;
                end
            end
            OP_LOAD: begin
                rd_pin_driven = 1'b0;
                rd_addr       = {ev.nibble, rd_addr[ADDR_BITS-1:NIBBLE_BITS]};
                rd_ready      = 1'b0;
            end
            OP_WRITE: rom_image[ev.rom_index] = ev.rom_byte;
            default: ;
        endcase
        res.data_bit    = rd_pin_driven ? rd_pin_level : 1'b0;
        res.data_drive  = rd_pin_driven;
        res.address_now = rd_addr;
    endtask

    function automatic void step_plan(inout fetch_plan_t p, input spr_in_t ev,
                                      output logic fetch, output logic [ROM_INDEX_BITS-1:0] idx);
        fetch = 1'b0;
        idx   = '0;
        if (ev.op == OP_READ) begin
            if (!p.ready) begin
                p.ready   = 1'b1;
                p.bit_pos = '0;
                fetch     = 1'b1;
                idx       = p.addr[ROM_INDEX_BITS-1:0];
            end else begin
                p.bit_pos = p.bit_pos + 1'b1;
            end
            if (p.bit_pos == BYTE_BITS) begin
                p.addr    = p.addr + 1'b1;
                p.bit_pos = '0;
                fetch     = 1'b1;
                idx       = p.addr[ROM_INDEX_BITS-1:0];
            end
        end else if (ev.op == OP_LOAD) begin
            p.addr  = {ev.nibble, p.addr[ADDR_BITS-1:NIBBLE_BITS]};
            p.ready = 1'b0;
        end
    endfunction

    function automatic spr_in_t random_event(input logic [1:0] op);
        spr_in_t ev;
        ev.op        = op;
        ev.nibble    = NIBBLE_BITS'($urandom);
        ev.rom_index = ROM_INDEX_BITS'($urandom);
        ev.rom_byte  = BYTE_BITS'($urandom);
        return ev;
    endfunction

    task automatic push_item(input spr_in_t ev);
        stim_item_t item;
        item.ev   = ev;
        item.hold = hold_pending;
        hold_pending = 1'b0;
        pending_events.push_back(item);
        if (ev.op != OP_SPARE)
            queued_count++;
        if (ev.op == OP_WRITE)
            rom_written[ev.rom_index] = 1'b1;
    endtask

    // a read that would fetch an unwritten entry gets a write to that entry just ahead of it
    task automatic queue_event(input spr_in_t ev);
        fetch_plan_t                nxt;
        logic                       fetch;
        logic [ROM_INDEX_BITS-1:0]  idx;
        spr_in_t                    fill;
        nxt = plan;
        step_plan(nxt, ev, fetch, idx);
        if (fetch && !rom_written[idx]) begin
            fill = random_event(OP_WRITE);
            fill.rom_index = idx;
            push_item(fill);
        end
        push_item(ev);
        plan = nxt;
    endtask

    task automatic queue_write(input logic [ROM_INDEX_BITS-1:0] idx, input logic [7:0] val);
        spr_in_t ev;
        ev = random_event(OP_WRITE);
        ev.rom_index = idx;
        ev.rom_byte  = val;
        queue_event(ev);
    endtask

    task automatic queue_load(input logic [NIBBLE_BITS-1:0] nib);
        spr_in_t ev;
        ev = random_event(OP_LOAD);
        ev.nibble = nib;
        queue_event(ev);
    endtask

    task automatic queue_reads(input int count);
        for (int i = 0; i < count; i++)
            queue_event(random_event(OP_READ));
    endtask

    task automatic queue_address(input logic [ADDR_BITS-1:0] a);
        for (int i = 0; i < ADDR_BITS / NIBBLE_BITS; i++)
            queue_load(a[i*NIBBLE_BITS +: NIBBLE_BITS]);
    endtask

    task automatic build_directed();
        spr_in_t ev;
        queue_write(14'h0000, 8'h5A);
        queue_write(14'h3FFF, 8'h00);
        queue_write(14'h0001, 8'hFF);
        // unused op with every field bit set
        ev = '1;
        queue_event(ev);
        // read before any load acts on address zero
        queue_reads(1);
        // top address: bank bits ignored, then wrap to zero after one byte
        queue_address(20'hFFFFF);
        queue_reads(9);
        queue_load(4'h0);
        ev = '0;
        ev.op = OP_SPARE;
        queue_event(ev);
    endtask

    task automatic build_random();
        int                    r;
        int                    next_hold;
        logic [ADDR_BITS-1:0]  a;
        spr_in_t               ev;
        next_hold = 600;
        while (queued_count < RANDOM_ITEMS) begin
            if (queued_count >= next_hold) begin
                hold_pending = 1'b1;
                next_hold += 700;
            end
            r = $urandom_range(0, 99);
            if (r < 55) begin
                case ($urandom_range(0, 3))
                    0: a = 20'hFFFF0 | ADDR_BITS'($urandom_range(0, 15));
                    1: a = ADDR_BITS'($urandom_range(0, 255));
                    default: a = ADDR_BITS'($urandom);
                endcase
                queue_address(a);
                for (int n = $urandom_range(1, 40); n > 0; n--) begin
                    if ($urandom_range(0, 99) < 5)
                        // sometimes overwrite the entry being shifted out
                        queue_write(($urandom_range(0, 1) != 0) ? plan.addr[ROM_INDEX_BITS-1:0]
                                                                : ROM_INDEX_BITS'($urandom),
                                    BYTE_BITS'($urandom));
                    queue_reads(1);
                end
            end else if (r < 70) begin
                for (int n = $urandom_range(1, 4); n > 0; n--)
                    queue_load(NIBBLE_BITS'($urandom));
                queue_reads($urandom_range(1, 12));
            end else if (r < 85) begin
                for (int n = $urandom_range(1, 6); n > 0; n--)
                    queue_write(ROM_INDEX_BITS'($urandom), BYTE_BITS'($urandom));
            end else if (r < 93) begin
                queue_reads($urandom_range(1, 10));
            end else if (r < 97) begin
                for (int n = $urandom_range(1, 3); n > 0; n--) begin
                    ev = random_event(OP_SPARE);
                    queue_event(ev);
                end
            end else begin
                queue_load(NIBBLE_BITS'($urandom));
            end
        end
    endtask

    // driver: feeds pending events, predicts on every input transfer
    always @(posedge clk or negedge rst_n) begin : drive_proc
        logic       took;
        spr_out_t   res;
        stim_item_t next_item;
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end else begin
            took = in_valid && !in_stall;
            if (took) begin
                predict_reader_output(in_data, res);
                expected_outputs.push_back(res);
                accepted_count++;
            end
            if (!in_valid || took) begin
                if (pending_events.size() != 0
                        && !(pending_events[0].hold && expected_outputs.size() != 0)
                        && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    next_item = pending_events.pop_front();
                    in_valid <= 1'b1;
                    in_data  <= next_item.ev;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each output transfer against the oldest prediction
    always @(posedge clk or negedge rst_n) begin : check_proc
        spr_out_t want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_outputs.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("%0t: result with nothing expected: bit %b drive %b addr %h",
                                 $realtime, out_data.data_bit, out_data.data_drive,
                                 out_data.address_now);
                end else begin
                    want = expected_outputs.pop_front();
                    if (out_data.data_bit !== want.data_bit
                            || out_data.data_drive !== want.data_drive
                            || out_data.address_now !== want.address_now) begin
                        error_count++;
                        if (error_count <= REPORT_MAX)
                            $display("%0t: bit/drive/addr exp %b/%b/%h got %b/%b/%h",
                                     $realtime, want.data_bit, want.data_drive, want.address_now,
                                     out_data.data_bit, out_data.data_drive,
                                     out_data.address_now);
                    end
                end
            end
            out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    initial begin
        for (int i = 0; i < ROM_DEPTH; i++)
            rom_written[i] = 1'b0;
        build_directed();
        build_random();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_events.size() != 0 || in_valid || expected_outputs.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("serial_phrase_rom_reader_top verification clean");
        else
            $display("serial_phrase_rom_reader_top verification failed");
        $finish;
    end

endmodule
